### sv/ghbdc_pkg.sv
// Shared constants, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps

package ghbdc_pkg;

   // Address width of every address field and of the address limit register.
   localparam int ADDR_BITS = 32;

   localparam int DEF_HISTORY_DEPTH = 1024;
   localparam int DEF_INDEX_DEPTH   = 512;

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ADDRESS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_WIDTH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREFETCH_DEPTH = 2'd2;

   localparam int WIDTH_BITS = 8;
   localparam int DEPTH_BITS = 4;

   localparam logic [ADDR_BITS-1:0]  MAX_ADDRESS_RST    = '1;
   localparam logic [WIDTH_BITS-1:0] SEARCH_WIDTH_RST   = 8'd100;
   localparam logic [DEPTH_BITS-1:0] PREFETCH_DEPTH_RST = 4'd5;

   // Most candidates one miss can produce.
   localparam logic [DEPTH_BITS-1:0] MAX_CANDIDATES = 4'd8;

   // Which link addresses the history read port.
   typedef enum logic [1:0] {
      RS_HEAD,
      RS_TPP,
      RS_N
   } rd_sel_type;

   typedef struct packed {
      logic       accept;
      logic       head_adv;
      rd_sel_type rd_sel;
      logic       unlink;
      logic       scan_next;
      logic       found;
      logic       insert;
      logic       link_a;
      logic       link_b;
      logic       p_get;
      logic       pp_get;
      logic       outer_issue;
      logic       cmp_latch;
      logic       inner_init;
      logic       inner_issue;
      logic       step_take;
      logic       advance;
      logic       finish_push;
   } dp_cmd_type;

   typedef struct packed {
      logic req_append;
      logic pref;
      logic row_lt_fill;
      logic scan_hit;
      logic e_ok;
      logic pp_ok;
      logic outer_go;
      logic match;
      logic inner_end;
      logic guard_done;
      logic cand_ok;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

endpackage

### sv/ghbdc_ctrl.sv
// Sequencing state machine for append, index scan, pair search and candidate walk.
`timescale 1ns / 1ps

module ghbdc_ctrl import ghbdc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_HEAD_RD,
      ST_UNLINK,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_INSERT,
      ST_LINK_A,
      ST_LINK_B,
      ST_P_RD,
      ST_P_GET,
      ST_PP_RD,
      ST_PP_GET,
      ST_OUTER,
      ST_CMP,
      ST_ADVANCE,
      ST_INNER,
      ST_STEP,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      step_go;

   assign req_stall = (state_ff != ST_IDLE);

   // A candidate can only be taken when the pending one has somewhere to go.
   assign step_go = !status.cand_ok || !status.pend_valid || status.out_free;

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RS_HEAD;
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.req_append) begin
                  cmd.head_adv = 1'b1;
                  state_in     = ST_HEAD_RD;
               end
            end
         end
         ST_HEAD_RD: begin
            cmd.rd_sel = RS_HEAD;
            state_in   = ST_UNLINK;
         end
         ST_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            state_in = status.row_lt_fill ? ST_SCAN_CMP : ST_INSERT;
         end
         ST_SCAN_CMP: begin
            if (status.scan_hit) begin
               cmd.found = 1'b1;
               state_in  = ST_LINK_A;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = ST_LINK_A;
         end
         ST_LINK_A: begin
            cmd.link_a = 1'b1;
            state_in   = ST_LINK_B;
         end
         ST_LINK_B: begin
            cmd.link_b = 1'b1;
            if (status.pref || !status.e_ok) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_P_RD;
            end
         end
         ST_P_RD: begin
            cmd.rd_sel = RS_TPP;
            state_in   = ST_P_GET;
         end
         ST_P_GET: begin
            cmd.p_get = 1'b1;
            state_in  = status.pp_ok ? ST_PP_RD : ST_IDLE;
         end
         ST_PP_RD: begin
            cmd.rd_sel = RS_TPP;
            state_in   = ST_PP_GET;
         end
         ST_PP_GET: begin
            cmd.pp_get = 1'b1;
            state_in   = ST_OUTER;
         end
         ST_OUTER: begin
            if (status.outer_go) begin
               cmd.outer_issue = 1'b1;
               cmd.rd_sel      = RS_TPP;
               state_in        = ST_CMP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_CMP: begin
            cmd.cmp_latch = 1'b1;
            if (status.match) begin
               cmd.inner_init = 1'b1;
               state_in       = ST_INNER;
            end else begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = ST_OUTER;
         end
         ST_INNER: begin
            if (status.inner_end) begin
               state_in = ST_FINISH;
            end else if (status.guard_done) begin
               state_in = ST_ADVANCE;
            end else begin
               cmd.inner_issue = 1'b1;
               cmd.rd_sel      = RS_N;
               state_in        = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.rd_sel = RS_N;
            if (step_go) begin
               cmd.step_take = 1'b1;
               state_in      = ST_INNER;
            end
         end
         ST_FINISH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.finish_push = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A candidate held back by a full output must not be dropped or advanced past.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && status.cand_ok && status.pend_valid && !status.out_free)
      |=> (state_ff == ST_STEP))
      else $error("candidate step advanced while the output was full");

   // The search only finishes back in idle once nothing is left pending.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && status.pend_valid && !status.out_free)
      |=> (state_ff == ST_FINISH))
      else $error("left finish with a pending candidate");

   // A new request is only taken in idle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (state_ff == ST_IDLE && !req_stall))
      else $error("request taken outside idle");

endmodule

### sv/ghbdc_datapath.sv
// History buffer, index table, delta search registers and output stage.
`timescale 1ns / 1ps

module ghbdc_datapath import ghbdc_pkg::*; #(
   parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
   parameter int INDEX_DEPTH   = DEF_INDEX_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ADDR_BITS-1:0]   csr_data,
   input  logic [ADDR_BITS-1:0]   req_access_address,
   input  logic [ADDR_BITS-1:0]   req_instr_address,
   input  logic                   req_is_miss,
   input  logic                   req_was_prefetched,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ADDR_BITS-1:0]   rsp_prefetch_address,
   output logic                   rsp_last_candidate,
   input  dp_cmd_type             cmd,
   output dp_status_type          status
);

   localparam int HIST_IDX_W = $clog2(HISTORY_DEPTH);
   localparam int LINK_W     = HIST_IDX_W + 1;
   localparam int IDX_IDX_W  = $clog2(INDEX_DEPTH);
   localparam int IDX_CNT_W  = IDX_IDX_W + 1;
   localparam logic [LINK_W-1:0]     LINK_NIL  = {1'b1, {HIST_IDX_W{1'b0}}};
   localparam logic [HIST_IDX_W-1:0] HIST_LAST = HIST_IDX_W'(HISTORY_DEPTH - 1);
   localparam logic [LINK_W-1:0]     HIST_CNT  = LINK_W'(HISTORY_DEPTH);
   localparam logic [IDX_IDX_W-1:0]  IDX_LAST  = IDX_IDX_W'(INDEX_DEPTH - 1);
   localparam logic [IDX_CNT_W-1:0]  IDX_CNT   = IDX_CNT_W'(INDEX_DEPTH);

   // Configuration.
   logic [ADDR_BITS-1:0]  max_address_ff;
   logic [WIDTH_BITS-1:0] search_width_ff;
   logic [DEPTH_BITS-1:0] prefetch_depth_ff;

   // Current request.
   logic [ADDR_BITS-1:0] addr_ff;
   logic [ADDR_BITS-1:0] pc_ff;
   logic                 pref_ff;

   // History bookkeeping; slots below fill_ff have been written.
   logic [LINK_W-1:0]     head_ff;
   logic [LINK_W-1:0]     head_in;
   logic [LINK_W-1:0]     fill_ff;
   logic [HIST_IDX_W-1:0] head_idx;

   // Index table bookkeeping; rows below ifill_ff are valid.
   logic [IDX_CNT_W-1:0] ifill_ff;
   logic [IDX_IDX_W-1:0] insert_ff;
   logic [IDX_CNT_W-1:0] row_ff;
   logic [LINK_W-1:0]    e_ff;

   // Memories.
   logic [ADDR_BITS-1:0] hist_addr_mem [HISTORY_DEPTH];
   logic [LINK_W-1:0]    hist_prev_mem [HISTORY_DEPTH];
   logic [LINK_W-1:0]    hist_next_mem [HISTORY_DEPTH];
   logic [ADDR_BITS-1:0] idx_instr_mem [INDEX_DEPTH];
   logic [LINK_W-1:0]    idx_ptr_mem   [INDEX_DEPTH];

   logic [HIST_IDX_W-1:0] hist_rd_idx;
   logic [ADDR_BITS-1:0]  hist_rd_addr_ff;
   logic [LINK_W-1:0]     hist_rd_prev_ff;
   logic [LINK_W-1:0]     hist_rd_next_ff;
   logic [ADDR_BITS-1:0]  idx_rd_instr_ff;
   logic [LINK_W-1:0]     idx_rd_ptr_ff;

   logic                  prev_we;
   logic [HIST_IDX_W-1:0] prev_wa;
   logic [LINK_W-1:0]     prev_wd;
   logic                  next_we;
   logic [HIST_IDX_W-1:0] next_wa;
   logic [LINK_W-1:0]     next_wd;
   logic                  ptr_we;
   logic [IDX_IDX_W-1:0]  ptr_wa;

   // Search registers.
   logic signed [ADDR_BITS:0] dp_ff;
   logic signed [ADDR_BITS:0] dpp_ff;
   logic [ADDR_BITS-1:0]      addr_t_ff;
   logic [LINK_W-1:0]         next_t_ff;
   logic [ADDR_BITS-1:0]      addr_tp_ff;
   logic [LINK_W-1:0]         next_tp_ff;
   logic [ADDR_BITS-1:0]      addr_tpp_ff;
   logic [LINK_W-1:0]         next_tpp_ff;
   logic [LINK_W-1:0]         prev_tpp_ff;
   logic [LINK_W-1:0]         tpp_link_ff;
   logic [ADDR_BITS-1:0]      c_addr_ff;
   logic [LINK_W-1:0]         n_link_ff;
   logic [WIDTH_BITS-1:0]     width_ff;
   logic [DEPTH_BITS-1:0]     depth_ff;
   logic [LINK_W-1:0]         guard_ff;
   logic [ADDR_BITS-1:0]      pend_ff;
   logic                      pend_valid_ff;

   // Output stage.
   logic                 rsp_valid_ff;
   logic [ADDR_BITS-1:0] rsp_addr_ff;
   logic                 rsp_last_ff;
   logic                 push;
   logic                 push_last;

   logic [DEPTH_BITS-1:0]     dmax;
   logic signed [ADDR_BITS:0] delta_a;
   logic signed [ADDR_BITS:0] delta_b;
   logic signed [ADDR_BITS:0] delta_n;
   logic [ADDR_BITS+1:0]      cand_sum;
   logic                      cand_ok;
   logic                      out_free;
   logic                      e_cand_ok;

   assign head_idx = head_ff[HIST_IDX_W-1:0];

   always_comb begin
      if (head_ff == LINK_NIL || head_idx == HIST_LAST) begin
         head_in = '0;
      end else begin
         head_in = head_ff + 1'b1;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RS_HEAD: hist_rd_idx = head_idx;
         RS_TPP:  hist_rd_idx = tpp_link_ff[HIST_IDX_W-1:0];
         RS_N:    hist_rd_idx = n_link_ff[HIST_IDX_W-1:0];
         default: hist_rd_idx = head_idx;
      endcase
   end

   assign dmax = (prefetch_depth_ff > MAX_CANDIDATES) ? MAX_CANDIDATES : prefetch_depth_ff;

   // Deltas are kept as signed newer-minus-older differences, one bit wider than an address.
   assign delta_a = $signed({1'b0, addr_t_ff}) - $signed({1'b0, addr_tp_ff});
   assign delta_b = $signed({1'b0, addr_tp_ff}) - $signed({1'b0, hist_rd_addr_ff});
   assign delta_n = $signed({1'b0, hist_rd_addr_ff}) - $signed({1'b0, c_addr_ff});

   // Candidate is the request address moved by one later delta. A downward move must
   // stay above zero, an upward one strictly below the address limit.
   assign cand_sum = {2'b00, addr_ff} + {delta_n[ADDR_BITS], delta_n};
   always_comb begin
      if (delta_n[ADDR_BITS]) begin
         cand_ok = !cand_sum[ADDR_BITS+1] && (cand_sum != '0);
      end else begin
         cand_ok = cand_sum < {2'b00, max_address_ff};
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // A stale pointer (slot never written, or the slot being reused now) breaks the chain.
   assign e_cand_ok = !idx_rd_ptr_ff[LINK_W-1] && (idx_rd_ptr_ff < fill_ff)
                      && (idx_rd_ptr_ff != head_ff);

   always_comb begin
      status             = '0;
      status.req_append  = req_is_miss | req_was_prefetched;
      status.pref        = pref_ff;
      status.row_lt_fill = row_ff < ifill_ff;
      status.scan_hit    = idx_rd_instr_ff == pc_ff;
      status.e_ok        = !e_ff[LINK_W-1];
      status.pp_ok       = !hist_rd_prev_ff[LINK_W-1];
      status.outer_go    = !tpp_link_ff[LINK_W-1] && (depth_ff < dmax)
                           && (width_ff < search_width_ff);
      status.match       = (delta_a == dp_ff) && (delta_b == dpp_ff);
      status.inner_end   = (n_link_ff == head_ff) || n_link_ff[LINK_W-1] || (depth_ff >= dmax);
      status.guard_done  = guard_ff >= HIST_CNT;
      status.cand_ok     = cand_ok;
      status.pend_valid  = pend_valid_ff;
      status.out_free    = out_free;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_address_ff    <= MAX_ADDRESS_RST;
         search_width_ff   <= SEARCH_WIDTH_RST;
         prefetch_depth_ff <= PREFETCH_DEPTH_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MAX_ADDRESS:    max_address_ff    <= csr_data;
            CSR_SEARCH_WIDTH:   search_width_ff   <= csr_data[WIDTH_BITS-1:0];
            CSR_PREFETCH_DEPTH: prefetch_depth_ff <= csr_data[DEPTH_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // History memory write ports.
   always_comb begin
      prev_we = 1'b0;
      prev_wa = head_idx;
      prev_wd = e_ff;
      if (cmd.unlink) begin
         prev_we = (head_ff < fill_ff) && !hist_rd_next_ff[LINK_W-1];
         prev_wa = hist_rd_next_ff[HIST_IDX_W-1:0];
         prev_wd = LINK_NIL;
      end else if (cmd.link_a) begin
         prev_we = 1'b1;
      end
   end

   always_comb begin
      next_we = 1'b0;
      next_wa = head_idx;
      next_wd = LINK_NIL;
      if (cmd.link_a) begin
         next_we = 1'b1;
      end else if (cmd.link_b) begin
         next_we = !e_ff[LINK_W-1];
         next_wa = e_ff[HIST_IDX_W-1:0];
         next_wd = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.link_a) begin
         hist_addr_mem[head_idx] <= addr_ff;
      end
      hist_rd_addr_ff <= hist_addr_mem[hist_rd_idx];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         hist_prev_mem[prev_wa] <= prev_wd;
      end
      hist_rd_prev_ff <= hist_prev_mem[hist_rd_idx];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         hist_next_mem[next_wa] <= next_wd;
      end
      hist_rd_next_ff <= hist_next_mem[hist_rd_idx];
   end

   // Index table.
   assign ptr_we = cmd.found | cmd.insert;
   assign ptr_wa = cmd.insert ? insert_ff : row_ff[IDX_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         idx_instr_mem[insert_ff] <= pc_ff;
      end
      idx_rd_instr_ff <= idx_instr_mem[row_ff[IDX_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ptr_we) begin
         idx_ptr_mem[ptr_wa] <= head_ff;
      end
      idx_rd_ptr_ff <= idx_ptr_mem[row_ff[IDX_IDX_W-1:0]];
   end

   // Control counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= LINK_NIL;
         fill_ff   <= '0;
         ifill_ff  <= '0;
         insert_ff <= '0;
      end else begin
         if (cmd.head_adv) begin
            head_ff <= head_in;
         end
         if (cmd.link_a && fill_ff != HIST_CNT) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.insert) begin
            insert_ff <= (insert_ff == IDX_LAST) ? '0 : insert_ff + 1'b1;
            if (ifill_ff != IDX_CNT) begin
               ifill_ff <= ifill_ff + 1'b1;
            end
         end
      end
   end

   // Request capture, scan and search payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         addr_ff <= req_access_address;
         pc_ff   <= req_instr_address;
         pref_ff <= req_was_prefetched;
      end
      if (cmd.unlink) begin
         row_ff <= '0;
      end else if (cmd.scan_next) begin
         row_ff <= row_ff + 1'b1;
      end
      if (cmd.found) begin
         e_ff <= e_cand_ok ? idx_rd_ptr_ff : LINK_NIL;
      end else if (cmd.insert) begin
         e_ff <= LINK_NIL;
      end
      if (cmd.link_b) begin
         tpp_link_ff <= e_ff;
      end
      if (cmd.p_get) begin
         addr_t_ff   <= hist_rd_addr_ff;
         next_t_ff   <= hist_rd_next_ff;
         dp_ff       <= $signed({1'b0, addr_ff}) - $signed({1'b0, hist_rd_addr_ff});
         tpp_link_ff <= hist_rd_prev_ff;
      end
      if (cmd.pp_get) begin
         addr_tp_ff  <= hist_rd_addr_ff;
         next_tp_ff  <= hist_rd_next_ff;
         dpp_ff      <= $signed({1'b0, addr_t_ff}) - $signed({1'b0, hist_rd_addr_ff});
         tpp_link_ff <= hist_rd_prev_ff;
         width_ff    <= '0;
      end
      if (cmd.outer_issue) begin
         width_ff <= width_ff + 1'b1;
      end
      if (cmd.cmp_latch) begin
         addr_tpp_ff <= hist_rd_addr_ff;
         next_tpp_ff <= hist_rd_next_ff;
         prev_tpp_ff <= hist_rd_prev_ff;
      end
      if (cmd.inner_init) begin
         c_addr_ff <= addr_t_ff;
         n_link_ff <= next_t_ff;
         guard_ff  <= '0;
      end
      if (cmd.inner_issue) begin
         guard_ff <= guard_ff + 1'b1;
      end
      if (cmd.step_take) begin
         c_addr_ff <= hist_rd_addr_ff;
         n_link_ff <= hist_rd_next_ff;
         if (cand_ok) begin
            pend_ff <= cand_sum[ADDR_BITS-1:0];
         end
      end
      if (cmd.advance) begin
         addr_t_ff   <= addr_tp_ff;
         next_t_ff   <= next_tp_ff;
         addr_tp_ff  <= addr_tpp_ff;
         next_tp_ff  <= next_tpp_ff;
         tpp_link_ff <= prev_tpp_ff;
      end
   end

   // One candidate is held back so the final one can be marked as last.
   assign push      = (cmd.step_take && cand_ok && pend_valid_ff) || cmd.finish_push;
   assign push_last = cmd.finish_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.pp_get) begin
            depth_ff <= '0;
         end else if (cmd.step_take && cand_ok) begin
            depth_ff <= depth_ff + 1'b1;
         end
         if (cmd.step_take && cand_ok) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.finish_push) begin
            pend_valid_ff <= 1'b0;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_addr_ff <= pend_ff;
         rsp_last_ff <= push_last;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_prefetch_address = rsp_addr_ff;
   assign rsp_last_candidate   = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= HIST_CNT) && (ifill_ff <= IDX_CNT))
      else $error("fill count beyond table depth");

   // Rows are handed out in order until the table is full.
   assert property (@(posedge clock) disable iff (reset)
      (ifill_ff == IDX_CNT) || (IDX_CNT_W'(insert_ff) == ifill_ff))
      else $error("insert pointer out of step with index fill");

   assert property (@(posedge clock) disable iff (reset)
      (head_ff != LINK_NIL) |-> (head_ff <= fill_ff))
      else $error("history head ahead of written slots");

   assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("candidate pushed into a full output register");

endmodule

### sv/ghb_delta_correlation_prefetcher_top.sv
// Top level of the global-history delta-correlation prefetcher.
`timescale 1ns / 1ps

// Delta-correlation prefetcher over a global history buffer. A request that is a
// miss or a hit on a prefetched block appends its address to a circular history of
// HISTORY_DEPTH slots; entries made by the same instruction address are chained, and
// a first-in-first-out index table of INDEX_DEPTH rows remembers the newest entry of
// each instruction address. On a miss (and not a prefetched hit) the two newest deltas
// of the chain are looked up in the older chain, and after a match each following
// delta, applied to the current address, gives one candidate, up to prefetch_depth
// (at most eight) candidates, the last one flagged by rsp_last_candidate. Requests
// are worked on one at a time and req_stall is high from the cycle after acceptance
// until the request is done. A plain hit leaves the block idle. An append scans the
// valid index rows until it finds the instruction address; the index scan is the
// dominant cost. The pair search then compares older chain positions (at most
// search_width) and steps through the candidate walk after each match, and waits
// while the result side stalls. All history and index state is tracked with fill
// counts, so no clearing pass follows reset. Configuration writes are always taken
// (csr_ready is tied high) and should only be issued while the block is idle.

module ghb_delta_correlation_prefetcher_top import ghbdc_pkg::*; #(
   parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
   parameter int INDEX_DEPTH   = DEF_INDEX_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ADDR_BITS-1:0]   req_access_address,
   input  logic [ADDR_BITS-1:0]   req_instr_address,
   input  logic                   req_is_miss,
   input  logic                   req_was_prefetched,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ADDR_BITS-1:0]   rsp_prefetch_address,
   output logic                   rsp_last_candidate,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ADDR_BITS-1:0]   csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Register writes need no back-pressure.
   assign csr_ready = 1'b1;

   ghbdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ghbdc_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .INDEX_DEPTH   (INDEX_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_valid & csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_access_address   (req_access_address),
      .req_instr_address    (req_instr_address),
      .req_is_miss          (req_is_miss),
      .req_was_prefetched   (req_was_prefetched),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_prefetch_address (rsp_prefetch_address),
      .rsp_last_candidate   (rsp_last_candidate),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule

### tb/ghbdc_checker.sv
// Watches the request, result and register channels, predicts candidates and compares them.
`timescale 1ns / 1ps

module ghbdc_checker import ghbdc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [ADDR_BITS-1:0]   req_access_address,
   input  logic [ADDR_BITS-1:0]   req_instr_address,
   input  logic                   req_is_miss,
   input  logic                   req_was_prefetched,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [ADDR_BITS-1:0]   rsp_prefetch_address,
   input  logic                   rsp_last_candidate,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ADDR_BITS-1:0]   csr_data,
   output int                     errors,
   output int                     pending
);

   localparam int HDEPTH = DEF_HISTORY_DEPTH;
   localparam int IDEPTH = DEF_INDEX_DEPTH;
   localparam int NIL    = -1;

   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic                 last;
   } candidate_t;

   typedef struct packed {
      logic [ADDR_BITS-1:0] mag;
      logic                 up;
   } delta_t;

   logic [ADDR_BITS-1:0] hist_addr [HDEPTH];
   bit                   hist_valid[HDEPTH];
   int                   hist_prev [HDEPTH];
   int                   hist_next [HDEPTH];
   int                   hist_head;
   logic [ADDR_BITS-1:0] row_pc    [IDEPTH];
   int                   row_ptr   [IDEPTH];
   bit                   row_valid [IDEPTH];
   int                   row_insert;

   logic [ADDR_BITS-1:0]  addr_limit;
   logic [WIDTH_BITS-1:0] scan_limit;
   logic [DEPTH_BITS-1:0] cand_limit;

   candidate_t expected_cands[$];

   function automatic bit slot_ok(int i);
      return i >= 0 && i < HDEPTH;
   endfunction

   function automatic logic [ADDR_BITS-1:0] addr_of(int i);
      return slot_ok(i) ? hist_addr[i] : '0;
   endfunction

   function automatic int prev_of(int i);
      return slot_ok(i) ? hist_prev[i] : NIL;
   endfunction

   function automatic int next_of(int i);
      return slot_ok(i) ? hist_next[i] : NIL;
   endfunction

   function automatic delta_t delta_between(logic [ADDR_BITS-1:0] older,
                                            logic [ADDR_BITS-1:0] newer);
      delta_t d;
      if (older > newer) begin
         d.mag = older - newer;
         d.up  = 1'b0;
      end else begin
         d.mag = newer - older;
         d.up  = 1'b1;
      end
      return d;
   endfunction

   task automatic clear_state();
      for (int i = 0; i < HDEPTH; i++) begin
         hist_addr[i]  = '0;
         hist_valid[i] = 0;
         hist_prev[i]  = NIL;
         hist_next[i]  = NIL;
      end
      for (int i = 0; i < IDEPTH; i++) begin
         row_pc[i]    = '0;
         row_ptr[i]   = 0;
         row_valid[i] = 0;
      end
      hist_head  = NIL;
      row_insert = 0;
      addr_limit = MAX_ADDRESS_RST;
      scan_limit = SEARCH_WIDTH_RST;
      cand_limit = PREFETCH_DEPTH_RST;
      expected_cands.delete();
   endtask

   // Finds the newest entry of this instruction address and points its row at the new head, or inserts a new row.
   function automatic int chain_tail(logic [ADDR_BITS-1:0] pc);
      int e;
      int i;
      for (i = 0; i < IDEPTH; i++) begin
         if (!row_valid[i]) break;
         if (row_pc[i] == pc) begin
            e = row_ptr[i];
            if (!slot_ok(e) || !hist_valid[e]) e = NIL;
            row_ptr[i] = hist_head;
            return e;
         end
      end
      i = row_insert % IDEPTH;
      row_pc[i]    = pc;
      row_ptr[i]   = hist_head;
      row_valid[i] = 1;
      row_insert   = (i + 1) % IDEPTH;
      return NIL;
   endfunction

   task automatic append_history(logic [ADDR_BITS-1:0] addr, logic [ADDR_BITS-1:0] pc);
      int h;
      int prev;
      hist_head = (hist_head == NIL) ? 0 : (hist_head + 1) % HDEPTH;
      h = hist_head;
      if (hist_valid[h]) begin
         hist_valid[h] = 0;
         if (slot_ok(hist_next[h])) hist_prev[hist_next[h]] = NIL;
      end
      prev = chain_tail(pc);
      if (slot_ok(prev)) hist_next[prev] = h;
      hist_prev[h]  = prev;
      hist_addr[h]  = addr;
      hist_valid[h] = 1;
      hist_next[h]  = NIL;
   endtask

   task automatic predict_candidates(logic [ADDR_BITS-1:0] addr, logic [ADDR_BITS-1:0] pc,
                                     logic miss, logic pref);
      int dmax;
      int depth;
      int width;
      int guard;
      int n_found;
      int p, pp, t, tp, tpp, c, n;
      delta_t dp, dpp, da, db, nd;
      logic [ADDR_BITS-1:0] f;
      candidate_t cand;
      if (!miss && !pref) return;
      append_history(addr, pc);
      if (pref) return;
      dmax    = (cand_limit > MAX_CANDIDATES) ? MAX_CANDIDATES : cand_limit;
      depth   = 0;
      width   = 0;
      n_found = 0;
      p = prev_of(hist_head);
      if (!slot_ok(p)) return;
      dp = delta_between(addr_of(p), addr);
      pp = prev_of(p);
      if (!slot_ok(pp)) return;
      dpp = delta_between(addr_of(pp), addr_of(p));
      t   = p;
      tp  = pp;
      tpp = prev_of(pp);
      while (slot_ok(tpp) && depth < dmax && width < scan_limit) begin
         width++;
         da = delta_between(addr_of(tp), addr_of(t));
         db = delta_between(addr_of(tpp), addr_of(tp));
         if (da == dp && db == dpp) begin
            c = t;
            n = next_of(c);
            guard = 0;
            while (n != hist_head && slot_ok(n) && depth < dmax && guard < HDEPTH) begin
               guard++;
               nd = delta_between(addr_of(c), addr_of(n));
               f  = addr;
               c  = n;
               n  = next_of(c);
               if (!nd.up && f > nd.mag) f = f - nd.mag;
               else if (nd.up && f < addr_limit && nd.mag < addr_limit - f) f = f + nd.mag;
               else continue;
               cand.addr = f;
               cand.last = 1'b0;
               expected_cands.push_back(cand);
               n_found++;
               depth++;
            end
            if (n == hist_head || !slot_ok(n)) break;
         end
         t   = tp;
         tp  = tpp;
         tpp = prev_of(tpp);
      end
      if (n_found > 0) expected_cands[expected_cands.size() - 1].last = 1'b1;
   endtask

   initial begin
      errors  = 0;
      pending = 0;
      clear_state();
   end

   always @(posedge clock) begin
      candidate_t want;
      if (reset) begin
         clear_state();
      end else begin
         // Results are compared before new expectations are added: a result of this
         // edge can never belong to a request accepted at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (expected_cands.size() == 0) begin
               errors++;
               $display("%0t: unexpected candidate %h last %b", $time,
                        rsp_prefetch_address, rsp_last_candidate);
            end else begin
               want = expected_cands.pop_front();
               if (want.addr !== rsp_prefetch_address) begin
                  errors++;
                  $display("%0t: prefetch_address expected %h actual %h", $time,
                           want.addr, rsp_prefetch_address);
               end
               if (want.last !== rsp_last_candidate) begin
                  errors++;
                  $display("%0t: last_candidate expected %b actual %b", $time,
                           want.last, rsp_last_candidate);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_ADDRESS: begin
                  addr_limit = csr_data;
               end
               CSR_SEARCH_WIDTH: begin
                  scan_limit = csr_data[WIDTH_BITS-1:0];
               end
               CSR_PREFETCH_DEPTH: begin
                  cand_limit = csr_data[DEPTH_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_candidates(req_access_address, req_instr_address,
                               req_is_miss, req_was_prefetched);
         end
      end
      pending = expected_cands.size();
   end

endmodule

### tb/testbench.sv
// Top of the prefetcher testbench: clock, reset, request stimulus, stalls and verdict.
`timescale 1ns / 1ps

module testbench;
   import ghbdc_pkg::*;

   // Extra quiet cycles after the block reports idle and every candidate is out.
   localparam int SETTLE_CYCLES = 3000;
   // Cycles with no handshake at all before the run is declared hung.
   localparam int HANG_LIMIT    = 20000;
   localparam int LONG_HOLD     = 400;
   localparam int STREAMS       = 6;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [ADDR_BITS-1:0]   req_access_address;
   logic [ADDR_BITS-1:0]   req_instr_address;
   logic                   req_is_miss;
   logic                   req_was_prefetched;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [ADDR_BITS-1:0]   rsp_prefetch_address;
   logic                   rsp_last_candidate;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [ADDR_BITS-1:0]   csr_data;
   int                     errors;
   int                     pending;

   // Bumped by the stimulus to ask the receiver for one long hold-off.
   int                     hold_asks;
   int                     hold_seen;
   int                     hold_left;
   int                     stall_mode;
   int                     idle_cycles;

   // Sender burst bookkeeping.
   int                     burst_left;

   // Well-formed request streams: one instruction address each, with a repeating
   // cycle of three deltas so that the pair search finds matches.
   logic [ADDR_BITS-1:0]   stream_pc   [STREAMS];
   logic [ADDR_BITS-1:0]   stream_addr [STREAMS];
   int                     stream_step [STREAMS][3];
   int                     stream_pos  [STREAMS];

   ghb_delta_correlation_prefetcher_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_access_address   (req_access_address),
      .req_instr_address    (req_instr_address),
      .req_is_miss          (req_is_miss),
      .req_was_prefetched   (req_was_prefetched),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_prefetch_address (rsp_prefetch_address),
      .rsp_last_candidate   (rsp_last_candidate),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   ghbdc_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_access_address   (req_access_address),
      .req_instr_address    (req_instr_address),
      .req_is_miss          (req_is_miss),
      .req_was_prefetched   (req_was_prefetched),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_prefetch_address (rsp_prefetch_address),
      .rsp_last_candidate   (rsp_last_candidate),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .errors               (errors),
      .pending              (pending)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver switches between stall patterns at random, and on request
   // holds off for a long stretch so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_seen  <= 0;
         hold_left  <= 0;
         stall_mode <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         if ($urandom_range(63, 0) == 0) stall_mode <= $urandom_range(2, 0);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(1, 0) == 0);
            default: rsp_stall <= ($urandom_range(4, 0) != 0);
         endcase
      end
   end

   // Watchdog: any handshake on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= HANG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   // Offers one request and returns at the edge where it is taken. Valid stays
   // high between requests of one burst; a random gap ends each burst.
   task automatic send_request(logic [ADDR_BITS-1:0] addr, logic [ADDR_BITS-1:0] pc,
                               logic miss, logic pref);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(20, 1)) @(posedge clock);
         burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(8, 1);
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_access_address <= addr;
      req_instr_address  <= pc;
      req_is_miss        <= miss;
      req_was_prefetched <= pref;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Lowers valid and waits until the block is idle again and every predicted
   // candidate has come out.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 || req_stall) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [ADDR_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(logic [ADDR_BITS-1:0] limit, logic [WIDTH_BITS-1:0] width,
                            logic [DEPTH_BITS-1:0] depth);
      drain();
      write_register(CSR_MAX_ADDRESS, limit);
      write_register(CSR_SEARCH_WIDTH, {{(ADDR_BITS-WIDTH_BITS){1'b0}}, width});
      write_register(CSR_PREFETCH_DEPTH, {{(ADDR_BITS-DEPTH_BITS){1'b0}}, depth});
   endtask

   // Restarts stream s with fresh deltas at a base near zero, near the top, or anywhere.
   task automatic restart_stream(int s);
      case ($urandom_range(3, 0))
         0: stream_addr[s] = $urandom_range(4096, 0);
         1: stream_addr[s] = 32'hFFFF_F000 + $urandom_range(4095, 0);
         default: stream_addr[s] = $urandom();
      endcase
      for (int k = 0; k < 3; k++) begin
         stream_step[s][k] = ($urandom_range(8, 0) - 4) * 64;
         if ($urandom_range(7, 0) == 0) stream_step[s][k] = $urandom() >> 12;
      end
      stream_pos[s] = 0;
   endtask

   // Mostly well-formed stream requests, the rest noise with random fields. Only
   // requests that reach the history count toward n.
   task automatic random_requests(int n);
      int done;
      int s;
      int roll;
      logic [ADDR_BITS-1:0] pc;
      done = 0;
      while (done < n) begin
         roll = $urandom_range(99, 0);
         if (roll < 80) begin
            s = $urandom_range(STREAMS - 1, 0);
            if ($urandom_range(49, 0) == 0) restart_stream(s);
            stream_addr[s] = stream_addr[s] + stream_step[s][stream_pos[s]];
            stream_pos[s]  = (stream_pos[s] + 1) % 3;
            if (roll < 5) begin
               send_request(stream_addr[s], stream_pc[s], 1'b0, 1'b0);
            end else if (roll < 12) begin
               send_request(stream_addr[s], stream_pc[s], $urandom_range(1, 0), 1'b1);
               done++;
            end else begin
               send_request(stream_addr[s], stream_pc[s], 1'b1, 1'b0);
               done++;
            end
         end else begin
            pc = ($urandom_range(1, 0) == 0) ? stream_pc[$urandom_range(STREAMS - 1, 0)]
                                             : $urandom();
            s = $urandom_range(3, 0);
            send_request($urandom(), pc, s[0], s[1]);
            if (s != 0) done++;
         end
      end
   endtask

   initial begin
      logic [ADDR_BITS-1:0] a;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_access_address <= '0;
      req_instr_address  <= '0;
      req_is_miss        <= 1'b0;
      req_was_prefetched <= 1'b0;
      csr_valid          <= 1'b0;
      csr_index          <= CSR_MAX_ADDRESS;
      csr_data           <= '0;
      hold_asks          <= 0;
      burst_left         = 0;
      for (int s = 0; s < STREAMS; s++) begin
         stream_pc[s] = (s == 0) ? 32'hFFFF_FFFF : $urandom();
         restart_stream(s);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset register values. A plain hit does nothing; a
      // steady upward stride gives matches; a short chain gives nothing at first.
      send_request(32'h0000_1000, 32'h0000_0040, 1'b0, 1'b0);
      a = 32'h0000_1000;
      for (int k = 0; k < 6; k++) begin
         send_request(a, 32'h0000_0040, 1'b1, 1'b0);
         a = a + 64;
      end
      // A downward stride close to zero: candidates that would go below zero are dropped.
      a = 32'h0000_0100;
      for (int k = 0; k < 5; k++) begin
         send_request(a, 32'hFFFF_FFFF, 1'b1, 1'b0);
         a = a - 64;
      end
      // Prefetched hits, with and without the miss flag, append but never search.
      send_request(32'hFFFF_FFFF, 32'h0000_0040, 1'b1, 1'b1);
      send_request(32'h0000_0000, 32'h0000_0040, 1'b0, 1'b1);
      // Extreme addresses on a fresh instruction address, alternating between zero and the top.
      send_request(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
      send_request(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0);
      send_request(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
      send_request(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0);
      send_request(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);

      // Pause the sender until everything is out, then hold off the receiver
      // while a run of random requests backs up into the request side.
      drain();
      hold_asks <= hold_asks + 1;
      random_requests(65);

      configure(32'hFFFF_FFFF, 8'd255, 4'd8);
      random_requests(65);

      configure(32'h8000_0000, 8'd1, 4'd1);
      random_requests(65);

      // Depth above eight saturates; a tiny address limit blocks most upward steps.
      configure(32'h0000_2000, 8'd3, 4'd15);
      random_requests(65);

      // Zero width, with depth zero and then eight: no search at all.
      configure(32'd0, 8'd0, 4'd0);
      random_requests(15);
      configure(32'hFFFF_FFFF, 8'd0, 4'd8);
      random_requests(15);

      // Many fresh instruction addresses grow the index table, so later lookups
      // scan a long run of rows.
      configure($urandom(), 8'd100, 4'd5);
      for (int k = 0; k < 100; k++) begin
         send_request($urandom(), 32'h1000_0000 + k, 1'b0, 1'b1);
      end
      random_requests(20);

      drain();
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
